// ----- hw/rtl/bni_pkg.sv -----
// Shared types and constants for the batch-norm inference unit.
// No dependencies; used by bni_root_div, batch_norm_inference_unit and the testbench.

package bni_pkg;

  // Field widths
  localparam int DATA_W = 16;                 // Q8.8 data
  localparam int CH_W   = 6;                  // channel field
  localparam int VAR_W  = 32;                 // Q16.16 variance
  localparam int EPS_W  = 16;                 // epsilon register
  localparam int COEF_W = 32;                 // Q16.16 scale / offset
  localparam int WORD_W = 2 * COEF_W;         // {scale, offset} per channel
  localparam int PROD_W = DATA_W + COEF_W;    // multiplier product

  // Root / divide datapath widths
  localparam int SUM_W  = VAR_W + 1;          // run_var + epsilon, no wrap
  localparam int ROOT_W = SUM_W + 16;         // radicand: sum << 16
  localparam int DEN_W  = 25;                 // floor(sqrt(radicand)) fits here
  localparam int QUO_W  = 40;                 // (|gain| << 24) + den/2

  // Defaults
  localparam int                 CHANNELS_DEF = 64;
  localparam logic [EPS_W-1:0]   EPS_RESET    = 16'd1;

  // Request types
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Configuration register map
  localparam int         CFG_ADDR_W  = 3;
  localparam int         CFG_IDX_W   = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = '0;

  typedef struct packed {
    logic done;
    logic den_zero;
  } root_div_status_t;

endpackage

// ----- hw/rtl/bni_param_mem.sv -----
// Per-channel coefficient store: one write port, one registered read port.
// Depends on nothing but its parameters.

module bni_param_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int WORD_W = 64
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bni_root_div.sv -----
// Iterative integer square root followed by restoring division, both on one
// shared subtract/compare unit. Depends on bni_pkg.

module bni_root_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bni_pkg::ROOT_W-1:0]    radicand_i,
  input  logic [bni_pkg::DATA_W-1:0]    mag_i,
  output bni_pkg::root_div_status_t     status_o,
  output logic [bni_pkg::QUO_W-1:0]     quot_o
);

  localparam int RW = bni_pkg::ROOT_W;
  localparam int DW = bni_pkg::DEN_W;
  localparam int QW = bni_pkg::QUO_W;
  localparam int MW = bni_pkg::DATA_W;

  typedef enum logic [3:0] {
    RD_IDLE = 4'b0001,
    RD_ROOT = 4'b0010,
    RD_PREP = 4'b0100,
    RD_DIV  = 4'b1000
  } rd_state_e;

  rd_state_e state_q, state_d;
  logic      done_q, done_d;

  logic [RW-1:0] v_q, v_d;
  logic [RW-1:0] r_q, r_d;
  logic [RW-1:0] bit_q, bit_d;
  logic [MW-1:0] mag_q, mag_d;
  logic [QW-1:0] num_q, num_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          zero_q, zero_d;

  // shared subtractor
  logic [DW:0]   rem_sh;
  logic [RW:0]   sub_a, sub_b, diff;
  logic          ge;

  assign rem_sh = {rem_q, num_q[QW-1]};

  always_comb begin
    if (state_q == RD_ROOT) begin
      sub_a = {1'b0, v_q};
      sub_b = {1'b0, r_q + bit_q};
    end else begin
      sub_a = (RW+1)'(rem_sh);
      sub_b = (RW+1)'(den_q);
    end
    diff = sub_a - sub_b;
    ge   = ~diff[RW];
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    v_d     = v_q;
    r_d     = r_q;
    bit_d   = bit_q;
    mag_d   = mag_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    zero_d  = zero_q;
    unique case (state_q)
      RD_IDLE: begin
        if (start_i) begin
          v_d     = radicand_i;
          r_d     = '0;
          bit_d   = RW'(1) << (RW - 1);
          mag_d   = mag_i;
          state_d = RD_ROOT;
        end
      end
      RD_ROOT: begin
        if (ge) begin
          v_d = diff[RW-1:0];
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = RD_PREP;
        end
      end
      RD_PREP: begin
        // r_q now holds the root; rounding term is den/2
        num_d   = {mag_q, {(QW-MW){1'b0}}} + QW'(r_q >> 1);
        den_d   = r_q[DW-1:0];
        zero_d  = (r_q == '0);
        rem_d   = '0;
        cnt_d   = 6'(QW - 1);
        state_d = RD_DIV;
      end
      RD_DIV: begin
        rem_d = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        num_d = {num_q[QW-2:0], ge};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = RD_IDLE;
        end
      end
      default: begin
        state_d = RD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RD_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
    mag_q  <= mag_d;
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    zero_q <= zero_d;
  end

  assign status_o.done     = done_q;
  assign status_o.den_zero = zero_q;
  assign quot_o            = num_q;

endmodule

// ----- hw/rtl/batch_norm_inference_unit.sv -----
// Batch-norm inference unit: sequencer, shared multiplier, output register.
// Depends on bni_pkg, bni_root_div and bni_param_mem.
//
//   Channel  Direction  Handshake              Payload
//   -------  ---------  ---------------------  ------------------------------------
//   in       sink       in_valid_i/in_stall_o  req_type, channel, sample, gain,
//                                              bias, run_mean, run_var
//   out      source     out_valid_o/out_stall_i result, out_channel
//   cfg      APB slave  psel/penable/pready    epsilon at byte address 0
//
// A sample request: accept and coefficient read, multiply, add/round/saturate into the
// output register. A load: 25 root steps, 1 setup, 40 divide steps, scale saturation,
// mean*scale, write. Reset clears the sequencer and output valid and sets epsilon to 1;
// the coefficient memory is not cleared, so the user must load a channel before use;
// the unit does not enforce this. in_stall_o is high while a request is in flight;
// only a full, stalled output register holds the last step.

module batch_norm_inference_unit #(
  parameter int CHANNELS = bni_pkg::CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bni_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,

  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [bni_pkg::CH_W-1:0]            channel_i,
  input  logic signed [bni_pkg::DATA_W-1:0]   sample_i,
  input  logic signed [bni_pkg::DATA_W-1:0]   gain_i,
  input  logic signed [bni_pkg::DATA_W-1:0]   bias_i,
  input  logic signed [bni_pkg::DATA_W-1:0]   run_mean_i,
  input  logic [bni_pkg::VAR_W-1:0]           run_var_i,

  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bni_pkg::DATA_W-1:0]   result_o,
  output logic [bni_pkg::CH_W-1:0]            out_channel_o
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W  = (ADDR_W > bni_pkg::CH_W) ? ADDR_W : bni_pkg::CH_W;
  localparam int DW     = bni_pkg::DATA_W;
  localparam int CW     = bni_pkg::COEF_W;
  localparam int PW     = bni_pkg::PROD_W;
  localparam int QW     = bni_pkg::QUO_W;

  localparam logic signed [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DATA_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ROOT = 6'b000010,  // waiting on root/divide
    S_LMUL = 6'b000100,  // run_mean * scale
    S_LOFF = 6'b001000,  // offset, coefficient write
    S_SMUL = 6'b010000,  // sample * scale
    S_SOUT = 6'b100000   // add offset, round, saturate
  } state_e;

  state_e state_q, state_d;

  // ---------------------------------------------------------------- config
  logic [bni_pkg::EPS_W-1:0]     eps_q;
  logic [bni_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[bni_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = (cfg_idx == bni_pkg::REG_EPSILON) ? 32'(eps_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= bni_pkg::EPS_RESET;
    end else if (cfg_wr && (cfg_idx == bni_pkg::REG_EPSILON)) begin
      eps_q <= pwdata[bni_pkg::EPS_W-1:0];
    end
  end

  // ---------------------------------------------------------------- accept
  logic              in_accept;
  logic              ch_ok;
  logic [EXT_W-1:0]  ch_ext;
  logic [ADDR_W-1:0] idx_in;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign ch_ok      = 32'(channel_i) < 32'(CHANNELS);
  assign ch_ext     = EXT_W'(channel_i);
  assign idx_in     = ch_ext[ADDR_W-1:0];

  // request context
  logic [bni_pkg::CH_W-1:0] ch_q;
  logic                     ok_q;
  logic [ADDR_W-1:0]        idx_q;
  logic signed [DW-1:0]     a_q;      // multiplier 16-bit operand
  logic signed [DW-1:0]     gain_q;
  logic signed [DW-1:0]     bias_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q   <= channel_i;
      ok_q   <= ch_ok;
      idx_q  <= idx_in;
      gain_q <= gain_i;
      bias_q <= bias_i;
      a_q    <= (req_type_i == bni_pkg::REQ_SAMPLE) ? sample_i : run_mean_i;
    end
  end

  // ---------------------------------------------------------------- root/div
  logic                             rd_start;
  logic [bni_pkg::SUM_W-1:0]        var_sum;
  logic [bni_pkg::ROOT_W-1:0]       radicand;
  logic [DW-1:0]                    gain_mag;
  bni_pkg::root_div_status_t        rd_status;
  logic [QW-1:0]                    quot;

  assign rd_start = in_accept & (req_type_i == bni_pkg::REQ_LOAD);
  assign var_sum  = bni_pkg::SUM_W'(run_var_i) + bni_pkg::SUM_W'(eps_q);
  assign radicand = {var_sum, 16'h0000};
  // |gain|; -32768 gives 0x8000 which is the right magnitude unsigned
  assign gain_mag = gain_i[DW-1] ? DW'(-gain_i) : DW'(gain_i);

  bni_root_div u_root_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rd_start),
    .radicand_i (radicand),
    .mag_i      (gain_mag),
    .status_o   (rd_status),
    .quot_o     (quot)
  );

  // ---------------------------------------------------------------- memory
  logic                          mem_we;
  logic                          mem_re;
  logic [bni_pkg::WORD_W-1:0]    mem_wdata;
  logic [bni_pkg::WORD_W-1:0]    mem_rdata;
  logic signed [CW-1:0]          mem_scale;
  logic signed [CW-1:0]          mem_offset;

  assign mem_re     = in_accept & (req_type_i == bni_pkg::REQ_SAMPLE) & ch_ok;
  assign mem_scale  = $signed(mem_rdata[2*CW-1:CW]);
  assign mem_offset = $signed(mem_rdata[CW-1:0]);

  bni_param_mem #(
    .DEPTH  (CHANNELS),
    .ADDR_W (ADDR_W),
    .WORD_W (bni_pkg::WORD_W)
  ) u_param_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_in),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------- scale
  // Signed saturation of the unsigned quotient; zero denominator saturates
  // by the sign of gain, and gives zero for a zero gain.
  logic signed [CW-1:0] sc_q, sc_calc;
  logic                 gain_neg, gain_zero;

  assign gain_neg  = gain_q[DW-1];
  assign gain_zero = (gain_q == '0);

  always_comb begin
    if (rd_status.den_zero) begin
      if (gain_zero) begin
        sc_calc = '0;
      end else if (gain_neg) begin
        sc_calc = COEF_MIN;
      end else begin
        sc_calc = COEF_MAX;
      end
    end else if (!gain_neg) begin
      sc_calc = (|quot[QW-1:CW-1]) ? COEF_MAX : $signed(quot[CW-1:0]);
    end else begin
      // magnitude above 2^31 saturates; exactly 2^31 negates to the minimum
      if ((|quot[QW-1:CW]) || (quot[CW-1] && (|quot[CW-2:0]))) begin
        sc_calc = COEF_MIN;
      end else begin
        sc_calc = -$signed(quot[CW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_ROOT) && rd_status.done) begin
      sc_q <= sc_calc;
    end
  end

  // ---------------------------------------------------------------- multiplier
  logic signed [CW-1:0] mul_b;
  logic signed [PW-1:0] prod_q;

  assign mul_b = (state_q == S_SMUL) ? mem_scale : sc_q;

  always_ff @(posedge clk_i) begin
    if ((state_q == S_SMUL) || (state_q == S_LMUL)) begin
      prod_q <= a_q * mul_b;
    end
  end

  // ---------------------------------------------------------------- offset
  // offset = bias*256 - round(mean*scale / 256), ties away from zero
  logic signed [PW-1:0]     prod_rnd;
  logic signed [PW-9:0]     mean_term;
  logic signed [PW-7:0]     off_wide;
  logic signed [CW-1:0]     off_sat;

  assign prod_rnd  = prod_q + (prod_q[PW-1] ? PW'(127) : PW'(128));
  assign mean_term = prod_rnd[PW-1:8];
  assign off_wide  = $signed({{(PW-6-DW-8){bias_q[DW-1]}}, bias_q, 8'h00})
                   - $signed({{2{mean_term[PW-9]}}, mean_term});

  always_comb begin
    if (off_wide[PW-7:CW-1] == {(PW-6-CW+1){off_wide[PW-7]}}) begin
      off_sat = off_wide[CW-1:0];
    end else if (off_wide[PW-7]) begin
      off_sat = COEF_MIN;
    end else begin
      off_sat = COEF_MAX;
    end
  end

  assign mem_we    = (state_q == S_LOFF) & ok_q;
  assign mem_wdata = {sc_q, off_sat};

  // ---------------------------------------------------------------- sample out
  // y = round((x*scale + offset*256) / 2^16), saturated to Q8.8
  localparam int AW = PW + 1;
  logic signed [AW-1:0]   acc;
  logic signed [AW-1:0]   acc_rnd;
  logic signed [AW-17:0]  y_wide;
  logic signed [DW-1:0]   y_sat;

  assign acc     = $signed({prod_q[PW-1], prod_q})
                 + $signed({{(AW-CW-8){mem_offset[CW-1]}}, mem_offset, 8'h00});
  assign acc_rnd = acc + (acc[AW-1] ? AW'(16'h7FFF) : AW'(17'h08000));
  assign y_wide  = acc_rnd[AW-1:16];

  always_comb begin
    if (y_wide[AW-17:DW-1] == {(AW-16-DW+1){y_wide[AW-17]}}) begin
      y_sat = y_wide[DW-1:0];
    end else if (y_wide[AW-17]) begin
      y_sat = DATA_MIN;
    end else begin
      y_sat = DATA_MAX;
    end
  end

  logic                 out_valid_q, out_valid_d;
  logic signed [DW-1:0] result_q;
  logic [bni_pkg::CH_W-1:0] out_ch_q;
  logic                 out_load;

  assign out_load = (state_q == S_SOUT) & (~out_valid_q | ~out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q <= ok_q ? y_sat : '0;
      out_ch_q <= ch_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_o      = result_q;
  assign out_channel_o = out_ch_q;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = (req_type_i == bni_pkg::REQ_SAMPLE) ? S_SMUL : S_ROOT;
        end
      end
      S_ROOT: begin
        if (rd_status.done) begin
          state_d = S_LMUL;
        end
      end
      S_LMUL: state_d = S_LOFF;
      S_LOFF: state_d = S_IDLE;
      S_SMUL: state_d = S_SOUT;
      S_SOUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- tb/tb_batch_norm_inference_unit.sv -----
// Self-checking testbench for batch_norm_inference_unit: load and sample requests with random
// idling, scale/offset/result predicted in-bench. Depends on bni_pkg and the unit's RTL.
module tb_batch_norm_inference_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bni_pkg::*;

  // Run limits. The slowest legal run is every request a load, plus stalls on
  // both sides; this ceiling sits several times above that.
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 120;     // longer than one load's root/divide pass
  localparam int NCH         = CHANNELS_DEF;

  // Byte addresses of the config space: epsilon and an unmapped slot
  localparam logic [CFG_ADDR_W-1:0] EPS_ADDR    = {REG_EPSILON, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR = {REG_EPSILON + 1'b1, 2'b00};

  typedef struct packed {
    logic                     req_type;
    logic [CH_W-1:0]          channel;
    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] gain;
    logic signed [DATA_W-1:0] bias;
    logic signed [DATA_W-1:0] run_mean;
    logic [VAR_W-1:0]         run_var;
  } bn_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [CH_W-1:0]          channel;
  } bn_res_t;

  // ---------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     psel       = 1'b0;
  logic                     penable    = 1'b0;
  logic                     pwrite     = 1'b0;
  logic [CFG_ADDR_W-1:0]    paddr      = '0;
  logic [31:0]              pwdata     = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  bn_req_t                  req_now    = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] result_o;
  logic [CH_W-1:0]          out_channel_o;

  batch_norm_inference_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_now.req_type),
    .channel_i    (req_now.channel),
    .sample_i     (req_now.sample),
    .gain_i       (req_now.gain),
    .bias_i       (req_now.bias),
    .run_mean_i   (req_now.run_mean),
    .run_var_i    (req_now.run_var),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result_o),
    .out_channel_o(out_channel_o)
  );

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  bn_req_t          req_backlog[$];     // requests waiting for the driver
  bn_res_t          expected_out_q[$];  // predicted results, oldest first
  logic [EPS_W-1:0] eps_shadow = EPS_RESET;
  int               scale_shadow[NCH];  // Q16.16 coefficients as the unit should hold them
  int               offset_shadow[NCH];
  bit               ch_loaded[NCH];
  int               loaded_list[$];
  int               err_cnt      = 0;
  int               cycle_cnt    = 0;
  int               results_seen = 0;
  int               hold_left    = 0;
  bit               hold_done    = 1'b0;
  logic             steady;

  // No idling on either side inside this window
  assign steady = (cycle_cnt >= 8000) && (cycle_cnt < 12000);

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------
  // Shift right by k, round to nearest, ties away from zero
  function automatic longint round_shr(longint v, int k);
    longint half;
    half = longint'(1) << (k - 1);
    if (v >= 0) return (v + half) >>> k;
    return -((-v + half) >>> k);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // floor(sqrt(v)); v < 2^50 so the root fits in 25 bits
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned cand;
    r = 0;
    for (int b = 24; b >= 0; b--) begin
      cand = r | (longint'(1) << b);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  // Load: scale = gain / sqrt(var + eps), offset = bias - mean * scale
  function automatic void coef_for_load(bn_req_t r);
    longint          g, sc, off;
    longint unsigned den, mag, q;
    g   = longint'($signed(r.gain));
    den = floor_root((longint'(r.run_var) + longint'(eps_shadow)) << 16);
    if (den == 0) begin
      // zero denominator: saturate toward gain's sign
      sc = (g > 0) ? 64'sh7FFF_FFFF : ((g < 0) ? -64'sh8000_0000 : 0);
    end else begin
      mag = longint'((g < 0) ? -g : g) << 24;
      q   = (mag + den / 2) / den;
      sc  = clamp((g < 0) ? -longint'(q) : longint'(q), -64'sh8000_0000, 64'sh7FFF_FFFF);
    end
    off = longint'($signed(r.bias)) * 256 - round_shr(longint'($signed(r.run_mean)) * sc, 8);
    off = clamp(off, -64'sh8000_0000, 64'sh7FFF_FFFF);
    scale_shadow[r.channel]  = int'(sc);
    offset_shadow[r.channel] = int'(off);
  endfunction

  // Sample: scale * x + offset, rounded and clamped to Q8.8
  function automatic bn_res_t norm_predict(bn_req_t r);
    bn_res_t res;
    longint  acc;
    acc = longint'($signed(r.sample)) * longint'(scale_shadow[r.channel])
        + longint'(offset_shadow[r.channel]) * 256;
    res.value   = DATA_W'(clamp(round_shr(acc, 16), -32768, 32767));
    res.channel = r.channel;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout at %0t after %0d cycles", $time, cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: predicts on every accepted request, then offers the next
  // one or idles. A stalled request is held untouched.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_now    <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (req_now.req_type == REQ_LOAD) coef_for_load(req_now);
        else expected_out_q.push_back(norm_predict(req_now));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (req_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
          req_now    <= req_backlog.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted result against the oldest prediction
  // and drives out_stall_i, including one long hold-off that backs the unit up.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    bn_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_out_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result %0d ch %0d", $time, result_o, out_channel_o);
        end else begin
          want = expected_out_q.pop_front();
          if (result_o !== want.value) begin
            err_cnt++;
            $display("%0t: result mismatch ch %0d expected %0d actual %0d",
                     $time, want.channel, want.value, result_o);
          end
          if (out_channel_o !== want.channel) begin
            err_cnt++;
            $display("%0t: out_channel mismatch expected %0d actual %0d",
                     $time, want.channel, out_channel_o);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!hold_done && results_seen >= 150) begin
        hold_done   <= 1'b1;
        hold_left   <= 300;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= steady ? 1'b0 : ($urandom_range(0, 99) < 25);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (called at a falling edge so the driver never races them)
  // ---------------------------------------------------------------------------
  task automatic push_load(int ch, logic [15:0] g, logic [15:0] b, logic [15:0] m,
                           logic [31:0] v);
    bn_req_t r;
    r.req_type = REQ_LOAD;
    r.channel  = CH_W'(ch);
    r.sample   = DATA_W'($urandom);   // ignored on a load
    r.gain     = g;
    r.bias     = b;
    r.run_mean = m;
    r.run_var  = v;
    req_backlog.push_back(r);
    if (!ch_loaded[ch]) begin
      ch_loaded[ch] = 1'b1;
      loaded_list.push_back(ch);
    end
  endtask

  task automatic push_sample(int ch, logic [15:0] x);
    bn_req_t r;
    r.req_type = REQ_SAMPLE;
    r.channel  = CH_W'(ch);
    r.sample   = x;
    r.gain     = DATA_W'($urandom);   // load fields are don't-care here
    r.bias     = DATA_W'($urandom);
    r.run_mean = DATA_W'($urandom);
    r.run_var  = $urandom;
    req_backlog.push_back(r);
  endtask

  // Mostly samples on loaded channels; loads mix tiny, huge and zero variances
  task automatic push_random(int n);
    logic [31:0] v;
    logic [15:0] x;
    int          pick;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 20) begin
        pick = $urandom_range(0, 9);
        v = (pick == 0) ? 32'd0 :
            (pick < 5)  ? 32'($urandom_range(0, 32'h3FFFF)) : $urandom;
        push_load($urandom_range(0, NCH - 1), 16'($urandom), 16'($urandom),
                  16'($urandom), v);
      end else begin
        pick = $urandom_range(0, 9);
        x = (pick == 0) ? 16'h7FFF : (pick == 1) ? 16'h8000 : 16'($urandom);
        push_sample(loaded_list[$urandom_range(0, loaded_list.size() - 1)], x);
      end
    end
  endtask

  // APB write: setup cycle, then access cycle (pready is always high)
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[CFG_ADDR_W-1:2] == REG_EPSILON) eps_shadow = data[EPS_W-1:0];
  endtask

  // Wait for all requests to go in and all results to come out; loads give
  // no result, so allow one more root/divide pass before touching config.
  task automatic drain();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || in_valid_i || expected_out_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);

    // Phase 1: epsilon at its reset value; field extremes
    push_load(0,  16'h7FFF, 16'h7FFF, 16'h8000, 32'h0000_0000);  // huge scale, offset clamps
    push_load(63, 16'h8000, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF);  // widest variance
    push_load(1,  16'h0100, 16'h0000, 16'h0000, 32'h0001_0000);  // unit scale
    push_load(2,  16'h0000, 16'h0123, 16'h0456, 32'h1234_5678);  // zero gain
    push_sample(0,  16'h7FFF);
    push_sample(0,  16'h8000);
    push_sample(0,  16'h0000);
    push_sample(63, 16'h7FFF);
    push_sample(63, 16'h8000);
    push_sample(1,  16'h0001);
    push_sample(1,  16'hFFFF);
    push_sample(1,  16'h7FFF);
    push_sample(1,  16'h8000);
    push_sample(2,  16'h5A5A);
    push_random(200);
    drain();

    // Phase 2: epsilon zero -> zero denominator with var zero, all gain signs
    cfg_write(EPS_ADDR, 32'h0000_0000);
    @(negedge clk_i);
    push_load(3, 16'h0200, 16'h0010, 16'h0001, 32'h0000_0000);
    push_load(4, 16'hFF00, 16'hFFF0, 16'hFFFF, 32'h0000_0000);
    push_load(5, 16'h0000, 16'h0040, 16'h7FFF, 32'h0000_0000);
    push_sample(3, 16'h0001);
    push_sample(3, 16'h0000);
    push_sample(4, 16'hFFFF);
    push_sample(4, 16'h0100);
    push_sample(5, 16'h7FFF);
    push_random(200);
    drain();

    // Phase 3: epsilon at max; upper pwdata bits must be dropped and the
    // unmapped address must not touch epsilon
    cfg_write(EPS_ADDR, 32'hABCD_FFFF);
    cfg_write(UNUSED_ADDR, 32'h0000_0055);
    @(negedge clk_i);
    push_random(200);
    drain();

    // Phase 4: random epsilon
    cfg_write(EPS_ADDR, $urandom);
    @(negedge clk_i);
    push_random(200);
    drain();

    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
